### hdl/ftdt_pkg.sv
package ftdt_pkg;

    localparam int MAX_PRECISION = 7;
    localparam int PREC_W        = $clog2(MAX_PRECISION + 1);
    localparam int INT_BITS      = 32;
    localparam int FRAC_BITS     = 32;
    localparam int MANT_BITS     = 24;
    localparam int INT_DIGITS    = 10;
    localparam int CNT_W         = $clog2(INT_DIGITS + 1);
    localparam int BITCNT_W      = $clog2(INT_BITS);

    localparam int EXP_BIAS      = 127;
    localparam int EXP_SPECIAL   = 255;
    localparam int EXP_POINT     = EXP_BIAS + MANT_BITS - 1 - FRAC_BITS;
    localparam int EXP_SAT       = EXP_POINT + FRAC_BITS + INT_BITS - MANT_BITS + 1;
    localparam int EXP_LOW       = EXP_POINT - (FRAC_BITS - 1);

    localparam int NAN_LEN       = 3;
    localparam int INF_LEN       = 4;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_N_UP  = 8'h4E;
    localparam logic [7:0] CHAR_A_LOW = 8'h61;
    localparam logic [7:0] CHAR_I_UP  = 8'h49;
    localparam logic [7:0] CHAR_N_LOW = 8'h6E;
    localparam logic [7:0] CHAR_F_LOW = 8'h66;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_ROUND,
        ST_SKIP,
        ST_SIGN,
        ST_INT,
        ST_DOT,
        ST_FRAC,
        ST_SPECIAL
    } state_t;

    typedef logic [3:0] digit_t;

    function automatic logic [7:0] digit_char(input digit_t d);
        return CHAR_ZERO + {4'h0, d};
    endfunction

    function automatic logic [7:0] special_char(input logic is_nan, input logic neg,
                                                input logic [1:0] idx);
        logic [7:0] c;
        c = CHAR_ZERO;
        if (is_nan) begin
            case (idx)
                2'd0: c = CHAR_N_UP;
                2'd1: c = CHAR_A_LOW;
                2'd2: c = CHAR_N_UP;
                default: c = CHAR_N_UP;
            endcase
        end else begin
            case (idx)
                2'd0: c = neg ? CHAR_MINUS : CHAR_PLUS;
                2'd1: c = CHAR_I_UP;
                2'd2: c = CHAR_N_LOW;
                default: c = CHAR_F_LOW;
            endcase
        end
        return c;
    endfunction

endpackage

### hdl/float_to_decimal_text.sv
// the input goes through a 32-step bit-serial binary to bcd conversion and rounding, then
// leading zeros of the integer part are skipped before the first character is offered
// one item is in flight at a time: a new input is taken only after its last character is emitted;
// nan and infinity skip the conversion; characters leave one per cycle unless the output stalls
// reset: synchronous active-low aresetn returns the sequencer to idle and empties the output
module float_to_decimal_text (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // float_bits[31:0], precision[35:32], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_code[7:0]
    output logic        m_tlast
);

    localparam int PW = ftdt_pkg::PREC_W;
    localparam int MP = ftdt_pkg::MAX_PRECISION;
    localparam int ND = ftdt_pkg::INT_DIGITS;
    localparam int CW = ftdt_pkg::CNT_W;
    localparam int BW = ftdt_pkg::BITCNT_W;

    ftdt_pkg::state_t state_reg, state_next;

    logic                  neg_reg, neg_next;
    logic                  nan_reg, nan_next;
    logic [PW-1:0]         prec_reg, prec_next;
    logic [31:0]           ip_reg, ip_next;
    logic [31:0]           fq_reg, fq_next;
    logic [ND-1:0][3:0]    bcd_reg, bcd_next;
    logic [MP-1:0][3:0]    frac_reg, frac_next;
    logic [3:0]            fstep_reg, fstep_next;
    logic                  round_reg, round_next;
    logic [ftdt_pkg::BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [7:0]            m_char_reg, m_char_next;
    logic                  m_last_reg, m_last_next;

    // input decode
    logic [7:0]            in_exp;
    logic [23:0]           in_mant;
    logic [63:0]           in_wide;
    logic [63:0]           in_fixed;
    logic [7:0]            exp_up;
    logic [7:0]            exp_down;
    logic [PW-1:0]         in_prec;

    // datapath helpers
    logic [ND-1:0][3:0]    bcd_adj;
    logic [35:0]           fq_x10;
    logic [3:0]            fq_digit;
    logic [MP-1:0][3:0]    frac_rnd;
    logic [ND-1:0][3:0]    bcd_rnd;
    logic                  rnd_carry;

    logic                  out_free;
    logic                  emit;
    logic [7:0]            emit_char;
    logic                  emit_last;
    logic [PW-1:0]         frac_idx;

    assign in_exp   = s_tdata[30:23];
    assign in_mant  = {1'b1, s_tdata[22:0]};
    assign in_wide  = {40'h0, in_mant};
    assign exp_up   = in_exp - 8'(ftdt_pkg::EXP_POINT);
    assign exp_down = 8'(ftdt_pkg::EXP_POINT) - in_exp;
    assign in_prec  = (s_tdata[35:32] > 4'(MP)) ? PW'(MP) : s_tdata[32 +: PW];

    always_comb begin
        if (in_exp >= 8'(ftdt_pkg::EXP_SAT)) begin
            in_fixed = {32'hFFFF_FFFF, 32'h0};
        end else if (in_exp >= 8'(ftdt_pkg::EXP_POINT)) begin
            in_fixed = in_wide << exp_up[5:0];
        end else if (in_exp >= 8'(ftdt_pkg::EXP_LOW)) begin
            in_fixed = in_wide >> exp_down[4:0];
        end else begin
            in_fixed = 64'h0;
        end
    end

    // double dabble correction and decimal fraction step
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    assign fq_x10   = {1'b0, fq_reg, 3'b000} + {3'b000, fq_reg, 1'b0};
    assign fq_digit = fq_x10[35:32];

    // round up into the fraction digits when the round flag is set, carry into the integer digits
    always_comb begin
        rnd_carry = round_reg;
        for (int i = 0; i < MP; i++) begin
            frac_rnd[i] = frac_reg[i];
            if (PW'(i) < prec_reg) begin
                if (rnd_carry) begin
                    frac_rnd[i] = (frac_reg[i] == 4'd9) ? 4'd0 : frac_reg[i] + 4'd1;
                end
                rnd_carry = rnd_carry && (frac_reg[i] == 4'd9);
            end
        end
        for (int j = 0; j < ND; j++) begin
            bcd_rnd[j] = bcd_reg[j];
            if (rnd_carry) begin
                bcd_rnd[j] = (bcd_reg[j] == 4'd9) ? 4'd0 : bcd_reg[j] + 4'd1;
            end
            rnd_carry = rnd_carry && (bcd_reg[j] == 4'd9);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign frac_idx = PW'(cnt_reg - CW'(1));

    always_comb begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        nan_next      = nan_reg;
        prec_next     = prec_reg;
        ip_next       = ip_reg;
        fq_next       = fq_reg;
        bcd_next      = bcd_reg;
        frac_next     = frac_reg;
        fstep_next    = fstep_reg;
        round_next    = round_reg;
        bit_cnt_next  = bit_cnt_reg;
        cnt_next      = cnt_reg;
        s_tready      = 1'b0;
        emit          = 1'b0;
        emit_char     = ftdt_pkg::CHAR_ZERO;
        emit_last     = 1'b0;

        case (state_reg)
            ftdt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    neg_next     = s_tdata[31];
                    nan_next     = (s_tdata[22:0] != 23'h0);
                    prec_next    = in_prec;
                    ip_next      = in_fixed[63:32];
                    fq_next      = in_fixed[31:0];
                    bcd_next     = '0;
                    frac_next    = '0;
                    fstep_next   = 4'd0;
                    round_next   = 1'b0;
                    bit_cnt_next = '0;
                    cnt_next     = '0;
                    if (in_exp == 8'(ftdt_pkg::EXP_SPECIAL)) begin
                        state_next = ftdt_pkg::ST_SPECIAL;
                    end else begin
                        state_next = ftdt_pkg::ST_CONV;
                    end
                end
            end
            ftdt_pkg::ST_CONV: begin
                bcd_next     = {bcd_adj[ND-1][2:0], bcd_adj[ND-2:0], ip_reg[31]};
                ip_next      = {ip_reg[30:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BW'(1);
                if (fstep_reg <= {1'b0, prec_reg}) begin
                    fq_next    = fq_x10[31:0];
                    fstep_next = fstep_reg + 4'd1;
                    if (fstep_reg < {1'b0, prec_reg}) begin
                        frac_next = {frac_reg[MP-2:0], fq_digit};
                    end else begin
                        round_next = (fq_digit >= 4'd5) || ((fq_digit == 4'd4) && fq_x10[31]);
                    end
                end
                if (bit_cnt_reg == '1) begin
                    state_next = ftdt_pkg::ST_ROUND;
                end
            end
            ftdt_pkg::ST_ROUND: begin
                frac_next  = frac_rnd;
                bcd_next   = bcd_rnd;
                cnt_next   = CW'(ND);
                state_next = ftdt_pkg::ST_SKIP;
            end
            ftdt_pkg::ST_SKIP: begin
                if ((bcd_reg[ND-1] == 4'd0) && (cnt_reg > CW'(1))) begin
                    bcd_next = {bcd_reg[ND-2:0], 4'h0};
                    cnt_next = cnt_reg - CW'(1);
                end else if (neg_reg) begin
                    state_next = ftdt_pkg::ST_SIGN;
                end else begin
                    state_next = ftdt_pkg::ST_INT;
                end
            end
            ftdt_pkg::ST_SIGN: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_char  = ftdt_pkg::CHAR_MINUS;
                    state_next = ftdt_pkg::ST_INT;
                end
            end
            ftdt_pkg::ST_INT: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = ftdt_pkg::digit_char(bcd_reg[ND-1]);
                    emit_last = (cnt_reg == CW'(1)) && (prec_reg == '0);
                    bcd_next  = {bcd_reg[ND-2:0], 4'h0};
                    cnt_next  = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_next = (prec_reg == '0) ? ftdt_pkg::ST_IDLE : ftdt_pkg::ST_DOT;
                    end
                end
            end
            ftdt_pkg::ST_DOT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_char  = ftdt_pkg::CHAR_DOT;
                    cnt_next   = CW'(prec_reg);
                    state_next = ftdt_pkg::ST_FRAC;
                end
            end
            ftdt_pkg::ST_FRAC: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = ftdt_pkg::digit_char(frac_reg[frac_idx]);
                    emit_last = (cnt_reg == CW'(1));
                    cnt_next  = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_next = ftdt_pkg::ST_IDLE;
                    end
                end
            end
            ftdt_pkg::ST_SPECIAL: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = ftdt_pkg::special_char(nan_reg, neg_reg, cnt_reg[1:0]);
                    emit_last = nan_reg ? (cnt_reg == CW'(ftdt_pkg::NAN_LEN - 1))
                                        : (cnt_reg == CW'(ftdt_pkg::INF_LEN - 1));
                    cnt_next  = cnt_reg + CW'(1);
                    if (emit_last) begin
                        state_next = ftdt_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ftdt_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_char_next   = emit_char;
            m_last_next   = emit_last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ftdt_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg     <= neg_next;
        nan_reg     <= nan_next;
        prec_reg    <= prec_next;
        ip_reg      <= ip_next;
        fq_reg      <= fq_next;
        bcd_reg     <= bcd_next;
        frac_reg    <= frac_next;
        fstep_reg   <= fstep_next;
        round_reg   <= round_next;
        bit_cnt_reg <= bit_cnt_next;
        cnt_reg     <= cnt_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tlast  = m_last_reg;

endmodule

### hdl/ftdt_checker.sv
module ftdt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,   // char_code[7:0]
    input logic        m_tlast
);

    // stalled transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    // one item in flight at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again straight after a transaction");

    // text never ends on a sign or a decimal point
    a_last_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata != ftdt_pkg::CHAR_MINUS)
                                && (m_tdata != ftdt_pkg::CHAR_DOT))
        else $error("text ends on a sign or point");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind float_to_decimal_text ftdt_checker u_ftdt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
